>>> rtl/tdd_slot_pattern_table_defines.svh
// Assertion macros used by the checker file.
`ifndef TDD_SLOT_PATTERN_TABLE_DEFINES_SVH
`define TDD_SLOT_PATTERN_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsp check failed");

// Next-cycle implication, disabled while reset is high.
`define TSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsp check failed");

// Next-cycle implication that is also checked through reset.
`define TSP_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tsp check failed");

`endif

>>> rtl/tsp_pkg.sv
package tsp_pkg;

  localparam int NUM_CELLS_DEF     = 4;
  localparam int PATTERN_SLOTS_DEF = 80;
  localparam int SLOT_SYMBOLS      = 14;

  localparam int MAX_SLOT_W = 24;
  localparam int SLOT_NUM_W = 32;
  localparam int PERIOD_W   = 7;
  localparam int TOTAL_W    = 7;
  localparam int SYM_CNT_W  = 4;
  localparam int TYPE_W     = 3;

  localparam logic [MAX_SLOT_W-1:0] MAX_SLOT_RESET = 24'd80;
  localparam logic [TOTAL_W-1:0]    TOTAL_MAX      = 7'd127;

  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  localparam logic [1:0] SYM_DL    = 2'd0;
  localparam logic [1:0] SYM_GUARD = 2'd2;

  localparam logic [TYPE_W-1:0] TY_INVALID = 3'd0;
  localparam logic [TYPE_W-1:0] TY_DL      = 3'd1;
  localparam logic [TYPE_W-1:0] TY_UL      = 3'd2;
  localparam logic [TYPE_W-1:0] TY_SP      = 3'd3;
  localparam logic [TYPE_W-1:0] TY_FDD     = 3'd4;

  typedef struct packed {
    logic [1:0]                   kind;
    logic [1:0]                   cell_req;
    logic                         duplex;
    logic [PERIOD_W-1:0]          period;
    logic [6:0]                   slot_index;
    logic [27:0]                  symbol_types;
    logic signed [SLOT_NUM_W-1:0] slot_number;
    logic [TYPE_W-1:0]            asked_type;
  } cmd_t;

  typedef struct packed {
    logic                match;
    logic [TYPE_W-1:0]   slot_type;
    logic [TOTAL_W-1:0]  dl_slot_total;
    logic [TOTAL_W-1:0]  ul_slot_total;
    logic                error;
  } rsp_t;

  typedef struct packed {
    logic                 loaded;
    logic [TYPE_W-1:0]    kind;
    logic [SYM_CNT_W-1:0] dl_syms;
    logic [SYM_CNT_W-1:0] ul_syms;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DIV_A,
    ST_DIV_B,
    ST_LOOKUP,
    ST_EVAL
  } state_t;

  // Bit 1 is the DL share, bit 0 the UL share of a stored slot.
  function automatic logic [1:0] share_of(input entry_t e);
    logic [1:0] s;
    s = 2'b00;
    if (e.loaded) begin
      if (e.kind == TY_DL) begin
        s = 2'b10;
      end else if (e.kind == TY_UL) begin
        s = 2'b01;
      end else if (e.kind == TY_SP) begin
        s = {e.dl_syms != '0, e.ul_syms != '0};
      end
    end
    return s;
  endfunction

  // One restoring remainder step; r is below d on entry and on return.
  function automatic logic [MAX_SLOT_W-1:0] rem_step(input logic [MAX_SLOT_W-1:0] r,
                                                     input logic b,
                                                     input logic [MAX_SLOT_W-1:0] d);
    logic [MAX_SLOT_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[MAX_SLOT_W-1:0];
  endfunction

endpackage

>>> rtl/tdd_slot_pattern_table.sv
// A rejected item, or a set or load with bad fields, answers with an error from idle; a
// load reads the old table entry, then writes the new one and updates the totals; a query
// runs 16 two-bit remainder steps on the slot number, 12 on the period, then a table read;
// a set cell sweeps its table entries one per cycle. Throughput: one item at a time; busy
// drops in the cycle the result word is shown. Reset: synchronous; afterwards busy stays
// high while the table is cleared. The receiver cannot stall; done marks each result word.
module tdd_slot_pattern_table #(
  parameter int NUM_CELLS     = tsp_pkg::NUM_CELLS_DEF,
  parameter int PATTERN_SLOTS = tsp_pkg::PATTERN_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  tsp_pkg::cmd_t                     cmd,
  input  logic                              cfg_wr_en,
  input  logic [tsp_pkg::MAX_SLOT_W-1:0]    cfg_wr_data,
  output logic                              done,
  output tsp_pkg::rsp_t                     result
);
  import tsp_pkg::*;

  localparam int DEPTH   = NUM_CELLS * PATTERN_SLOTS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CELL_W  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int SLOT_W  = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
  localparam int TOT_W   = $clog2(PATTERN_SLOTS + 1);
  localparam int A_STEPS = SLOT_NUM_W / 2;
  localparam int B_STEPS = MAX_SLOT_W / 2;
  localparam int STEP_W  = $clog2(A_STEPS);
  localparam int PAD_W   = SLOT_NUM_W - MAX_SLOT_W;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [CELL_W-1:0] c,
                                                input logic [PERIOD_W-1:0] i);
    return ADDR_W'(int'(c) * PATTERN_SLOTS + int'(i));
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_total(input logic [TOT_W-1:0] v);
    if (int'(v) > int'(TOTAL_MAX)) begin
      return TOTAL_MAX;
    end
    return TOTAL_W'(v);
  endfunction

  state_t                 state, state_next;
  logic [MAX_SLOT_W-1:0]  max_slot;
  logic [NUM_CELLS-1:0]   cell_fdd;
  logic [PERIOD_W-1:0]    cell_per [NUM_CELLS];
  logic [TOT_W-1:0]       dl_tot   [NUM_CELLS];
  logic [TOT_W-1:0]       ul_tot   [NUM_CELLS];

  entry_t                 mem [DEPTH];
  entry_t                 rd_data;
  logic                   mem_we;
  logic                   mem_re;
  logic [ADDR_W-1:0]      mem_waddr;
  entry_t                 mem_wdata;

  logic [1:0]             kind_q;
  logic [CELL_W-1:0]      cell_q;
  logic [TYPE_W-1:0]      asked_q;
  logic                   neg_q;
  entry_t                 new_entry_q;
  logic [ADDR_W-1:0]      addr_q;
  logic [ADDR_W-1:0]      clr_cnt;
  logic [SLOT_W-1:0]      sw_cnt;
  logic [SLOT_NUM_W-1:0]  dvd;
  logic [MAX_SLOT_W-1:0]  rem;
  logic [MAX_SLOT_W-1:0]  divisor;
  logic [STEP_W-1:0]      step_cnt;

  logic                   acc;
  logic                   cell_ok;
  logic [CELL_W-1:0]      cell_in;
  logic                   reject;
  logic                   set_bad;
  logic                   load_bad;
  logic [SYM_CNT_W-1:0]   nd_cnt, ng_cnt, nu_cnt;
  entry_t                 entry_in;
  logic [SLOT_NUM_W-1:0]  mag;
  logic [MAX_SLOT_W-1:0]  m_eff;
  logic [MAX_SLOT_W-1:0]  r1, r2, r_fix;
  logic [PERIOD_W-1:0]    q_idx;
  logic [1:0]             old_sh, new_sh;
  logic [TOT_W-1:0]       dl_new, ul_new;
  logic                   q_match;
  logic [TYPE_W-1:0]      q_type;
  logic                   rsp_fire;
  rsp_t                   rsp_next;

  assign busy    = (state != ST_IDLE);
  assign acc     = start && !busy;
  assign cell_ok = (int'(cmd.cell_req) < NUM_CELLS);
  assign cell_in = cell_ok ? CELL_W'(cmd.cell_req) : '0;
  assign reject  = (cmd.kind == KIND_BAD) || !cell_ok;
  assign set_bad = cmd.duplex && ((cmd.period == '0) || (int'(cmd.period) > PATTERN_SLOTS));
  assign load_bad = cell_fdd[cell_in] || (cmd.slot_index >= cell_per[cell_in]) ||
                    (int'(cmd.slot_index) >= PATTERN_SLOTS);

  always_comb begin
    nd_cnt = '0;
    ng_cnt = '0;
    for (int i = 0; i < SLOT_SYMBOLS; i++) begin
      if (cmd.symbol_types[2*i +: 2] == SYM_DL) begin
        nd_cnt = nd_cnt + SYM_CNT_W'(1);
      end else if (cmd.symbol_types[2*i +: 2] == SYM_GUARD) begin
        ng_cnt = ng_cnt + SYM_CNT_W'(1);
      end
    end
    nu_cnt = SYM_CNT_W'(SLOT_SYMBOLS) - nd_cnt - ng_cnt;
    entry_in = '0;
    entry_in.loaded = 1'b1;
    if (nu_cnt == '0 && ng_cnt == '0) begin
      entry_in.kind = TY_DL;
    end else if (nd_cnt == '0 && ng_cnt == '0) begin
      entry_in.kind = TY_UL;
    end else begin
      entry_in.kind    = TY_SP;
      entry_in.dl_syms = nd_cnt;
      entry_in.ul_syms = nu_cnt;
    end
  end

  assign mag   = cmd.slot_number[SLOT_NUM_W-1] ? (~cmd.slot_number + SLOT_NUM_W'(1))
                                              : cmd.slot_number;
  assign m_eff = (max_slot == '0) ? MAX_SLOT_W'(1) : max_slot;

  assign r1    = rem_step(rem, dvd[SLOT_NUM_W-1], divisor);
  assign r2    = rem_step(r1, dvd[SLOT_NUM_W-2], divisor);
  assign r_fix = (neg_q && r2 != '0) ? (divisor - r2) : r2;
  assign q_idx = (int'(r2[PERIOD_W-1:0]) >= PATTERN_SLOTS) ? '0 : r2[PERIOD_W-1:0];

  assign old_sh = share_of(rd_data);
  assign new_sh = share_of(new_entry_q);
  assign dl_new = dl_tot[cell_q] - TOT_W'(old_sh[1]) + TOT_W'(new_sh[1]);
  assign ul_new = ul_tot[cell_q] - TOT_W'(old_sh[0]) + TOT_W'(new_sh[0]);

  always_comb begin
    q_match = 1'b0;
    q_type  = TY_INVALID;
    if (cell_fdd[cell_q]) begin
      q_type  = TY_FDD;
      q_match = 1'b1;
    end else begin
      if (rd_data.loaded) begin
        q_type = rd_data.kind;
      end
      if (asked_q == q_type) begin
        q_match = 1'b1;
      end else if (q_type == TY_SP) begin
        if (asked_q == TY_DL && rd_data.dl_syms != '0) begin
          q_match = 1'b1;
        end
        if (asked_q == TY_UL && rd_data.ul_syms != '0) begin
          q_match = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc && !reject) begin
          unique case (cmd.kind)
            KIND_SET:   state_next = set_bad ? ST_IDLE : ST_SWEEP;
            KIND_LOAD:  state_next = load_bad ? ST_IDLE : ST_LOOKUP;
            KIND_QUERY: state_next = ST_DIV_A;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        if (sw_cnt == SLOT_W'(PATTERN_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV_A: begin
        if (step_cnt == STEP_W'(A_STEPS - 1)) begin
          state_next = ST_DIV_B;
        end
      end
      ST_DIV_B: begin
        if (step_cnt == STEP_W'(B_STEPS - 1)) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_next = ST_EVAL;
      ST_EVAL:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    rsp_fire  = 1'b0;
    rsp_next  = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
      end
      ST_IDLE: begin
        if (acc) begin
          if (reject) begin
            rsp_fire       = 1'b1;
            rsp_next.error = 1'b1;
          end else if ((cmd.kind == KIND_SET && set_bad) ||
                       (cmd.kind == KIND_LOAD && load_bad)) begin
            rsp_fire               = 1'b1;
            rsp_next.error         = 1'b1;
            rsp_next.dl_slot_total = sat_total(dl_tot[cell_in]);
            rsp_next.ul_slot_total = sat_total(ul_tot[cell_in]);
          end
        end
      end
      ST_SWEEP: begin
        mem_we = 1'b1;
        if (sw_cnt == SLOT_W'(PATTERN_SLOTS - 1)) begin
          rsp_fire               = 1'b1;
          rsp_next.dl_slot_total = sat_total(dl_tot[cell_q]);
          rsp_next.ul_slot_total = sat_total(ul_tot[cell_q]);
        end
      end
      ST_LOOKUP: mem_re = 1'b1;
      ST_EVAL: begin
        rsp_fire = 1'b1;
        if (kind_q == KIND_LOAD) begin
          mem_we                 = 1'b1;
          mem_wdata              = new_entry_q;
          rsp_next.slot_type     = new_entry_q.kind;
          rsp_next.dl_slot_total = sat_total(dl_new);
          rsp_next.ul_slot_total = sat_total(ul_new);
        end else begin
          rsp_next.match         = q_match;
          rsp_next.slot_type     = q_type;
          rsp_next.dl_slot_total = sat_total(dl_tot[cell_q]);
          rsp_next.ul_slot_total = sat_total(ul_tot[cell_q]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[addr_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      done     <= 1'b0;
      clr_cnt  <= '0;
      max_slot <= MAX_SLOT_RESET;
      cell_fdd <= '0;
      for (int c = 0; c < NUM_CELLS; c++) begin
        cell_per[c] <= PERIOD_W'(1);
        dl_tot[c]   <= '0;
        ul_tot[c]   <= '0;
      end
    end else begin
      state <= state_next;
      done  <= rsp_fire;
      if (cfg_wr_en) begin
        max_slot <= cfg_wr_data;
      end
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (acc && !reject && cmd.kind == KIND_SET && !set_bad) begin
        if (!cmd.duplex) begin
          cell_fdd[cell_in] <= 1'b1;
          cell_per[cell_in] <= PERIOD_W'(1);
          dl_tot[cell_in]   <= TOT_W'(1);
          ul_tot[cell_in]   <= TOT_W'(1);
        end else begin
          cell_fdd[cell_in] <= 1'b0;
          cell_per[cell_in] <= cmd.period;
          dl_tot[cell_in]   <= '0;
          ul_tot[cell_in]   <= '0;
        end
      end
      if (state == ST_EVAL && kind_q == KIND_LOAD) begin
        dl_tot[cell_q] <= dl_new;
        ul_tot[cell_q] <= ul_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_fire) begin
      result <= rsp_next;
    end
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          kind_q      <= cmd.kind;
          cell_q      <= cell_in;
          asked_q     <= cmd.asked_type;
          neg_q       <= cmd.slot_number[SLOT_NUM_W-1];
          new_entry_q <= entry_in;
          sw_cnt      <= '0;
          step_cnt    <= '0;
          rem         <= '0;
          dvd         <= mag;
          divisor     <= m_eff;
          addr_q      <= (cmd.kind == KIND_SET) ? addr_of(cell_in, '0)
                                                : addr_of(cell_in, cmd.slot_index);
        end
      end
      ST_SWEEP: begin
        addr_q <= addr_q + ADDR_W'(1);
        sw_cnt <= sw_cnt + SLOT_W'(1);
      end
      ST_DIV_A: begin
        if (step_cnt == STEP_W'(A_STEPS - 1)) begin
          rem      <= '0;
          dvd      <= {r_fix, {PAD_W{1'b0}}};
          divisor  <= MAX_SLOT_W'(cell_per[cell_q]);
          step_cnt <= '0;
        end else begin
          rem      <= r2;
          dvd      <= dvd << 2;
          step_cnt <= step_cnt + STEP_W'(1);
        end
      end
      ST_DIV_B: begin
        rem      <= r2;
        dvd      <= dvd << 2;
        step_cnt <= step_cnt + STEP_W'(1);
        if (step_cnt == STEP_W'(B_STEPS - 1)) begin
          addr_q <= addr_of(cell_q, q_idx);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/tsp_checker.sv
`include "tdd_slot_pattern_table_defines.svh"

module tsp_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input tsp_pkg::rsp_t result
);
  import tsp_pkg::*;

  // An accepted word either answers at once or keeps the block busy.
  `TSP_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)
  // A rejected word carries no slot answer.
  `TSP_ASSERT_NOW(a_error_clean, done && result.error, !result.match && result.slot_type == TY_INVALID)
  // An FDD cell serves every asked type.
  `TSP_ASSERT_NOW(a_fdd_match, done && result.slot_type == TY_FDD, result.match)
  // Reset starts the table clearing pass.
  `TSP_ASSERT_NEXT_RST(a_reset_busy, rst, busy && !done)

endmodule

bind tdd_slot_pattern_table tsp_checker u_tsp_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
